@@ hw/rtl/plb_pkg.sv @@
// Shared types, codes and arithmetic helpers for the pixel layer blend block.
`default_nettype none

package plb_pkg;

    localparam int NUM_LANES  = 3;
    localparam int NUM_STAGES = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int PROD_W     = 20;
    localparam int MUL8_W     = 24;

    typedef enum logic [3:0] {
        BLEND_NORMAL     = 4'd0,
        BLEND_ADD        = 4'd1,
        BLEND_SUBTRACT   = 4'd2,
        BLEND_DIFFERENCE = 4'd3,
        BLEND_LIGHTEN    = 4'd4,
        BLEND_DARKEN     = 4'd5,
        BLEND_DIVIDE     = 4'd6,
        BLEND_MULTIPLY   = 4'd7,
        BLEND_SCREEN     = 4'd8,
        BLEND_OVERLAY    = 4'd9
    } t_blend_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IDX_MODE       = 2'd0,
        CFG_IDX_OPACITY    = 2'd1,
        CFG_IDX_SRC_ALPHA  = 2'd2,
        CFG_IDX_DEST_ALPHA = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] opacity;
        logic       src_has_alpha;
        logic       dest_has_alpha;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        mode:           BLEND_NORMAL,
        opacity:        8'd255,
        src_has_alpha:  1'b1,
        dest_has_alpha: 1'b1
    };

    typedef struct packed {
        logic [7:0] dest_red;
        logic [7:0] dest_green;
        logic [7:0] dest_blue;
        logic [7:0] dest_alpha;
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_pix_out;

    typedef logic signed [PROD_W-1:0] t_prod;

    // Rounded divide by 255 of a product, floor shifts for negative values.
    function automatic logic signed [MUL8_W-1:0] mul8_round(
        input logic signed [MUL8_W-1:0] prod
    );
        logic signed [MUL8_W-1:0] t;
        t = prod + MUL8_W'(signed'(9'sd128));
        mul8_round = ((t >>> 8) + t) >>> 8;
    endfunction

    // One restoring division step: returns {quotient bit, new remainder}.
    function automatic logic [9:0] div_step(
        input logic [8:0] rem,
        input logic [8:0] dvs
    );
        logic [9:0] sh;
        sh = {rem, 1'b0};
        if (sh >= {1'b0, dvs}) begin
            div_step = {1'b1, 9'(sh - {1'b0, dvs})};
        end else begin
            div_step = {1'b0, sh[8:0]};
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/plb_stream_if.sv @@
// Valid/ready stream channel carrying one pixel item.
`default_nettype none

interface plb_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pixel_layer_blend_core.sv @@
// Top level of the pixel layer blend block: config registers, pipeline control, lanes.
//
// Usage:
//   i_pix carries one item per handshake: a destination and a source RGBA8 pixel.
//   o_pix returns one blended RGBA8 pixel for every accepted item, in order.
//   Both channels move an item at a rising edge with valid and ready high.
//   i_cfg_we/i_cfg_idx/i_cfg_data write blend mode, opacity and the two
//   has-alpha flags; write them only while no item is in flight.
// Timing:
//   Seven register stages. One item per cycle sustained while o_pix.ready is
//   high: three color lanes and the alpha unit work in parallel, the divider
//   retires three, three and two quotient bits in stages one to three, and
//   each multiply has a stage of its own.
// Reset:
//   Clears all stage valid bits and loads mode normal, opacity 255 and both
//   has-alpha flags set.
// Stall:
//   Each stage advances when the stage after it is empty or moving, so bubbles
//   collapse; i_pix.ready falls only once all seven stages hold items.
`default_nettype none

module pixel_layer_blend_core import plb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    plb_stream_if.sink            i_pix,
    plb_stream_if.source          o_pix
);

    t_cfg                  r_cfg;
    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] w_en;

    logic [7:0] w_d [NUM_LANES];
    logic [7:0] w_s [NUM_LANES];
    logic [7:0] w_lane_d [NUM_LANES];
    t_prod      w_lane_prod [NUM_LANES];
    logic [7:0] w_alpha, w_oa;
    t_pix_out   w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_MODE:       r_cfg.mode           <= i_cfg_data[3:0];
                CFG_IDX_OPACITY:    r_cfg.opacity        <= i_cfg_data[7:0];
                CFG_IDX_SRC_ALPHA:  r_cfg.src_has_alpha  <= i_cfg_data[0];
                CFG_IDX_DEST_ALPHA: r_cfg.dest_has_alpha <= i_cfg_data[0];
            endcase
        end
    end

    // advance a stage when the next one is empty or advancing
    always_comb begin
        w_en[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || o_pix.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            w_en[i] = !r_v[i] || w_en[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_pix.valid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (w_en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    assign i_pix.ready = w_en[0];
    assign o_pix.valid = r_v[NUM_STAGES-1];
    assign o_pix.data  = w_out;

    assign w_d[0] = i_pix.data.dest_red;
    assign w_d[1] = i_pix.data.dest_green;
    assign w_d[2] = i_pix.data.dest_blue;
    assign w_s[0] = i_pix.data.src_red;
    assign w_s[1] = i_pix.data.src_green;
    assign w_s[2] = i_pix.data.src_blue;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        plb_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_cfg   (r_cfg),
            .i_d     (w_d[g]),
            .i_s     (w_s[g]),
            .i_alpha (w_alpha),
            .o_d     (w_lane_d[g]),
            .o_prod  (w_lane_prod[g])
        );
    end

    plb_alpha u_alpha (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_da    (i_pix.data.dest_alpha),
        .i_sa    (i_pix.data.src_alpha),
        .o_alpha (w_alpha),
        .o_oa    (w_oa)
    );

    plb_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en[NUM_STAGES-1]),
        .i_cfg  (r_cfg),
        .i_d    (w_lane_d),
        .i_prod (w_lane_prod),
        .i_oa   (w_oa),
        .o_pix  (w_out)
    );

    a_blocked_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (&r_v))
        else $error("input blocked while a pipeline stage is empty");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_v[0])
        else $error("accepted item did not enter the first stage");

    a_no_item_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NUM_STAGES-2] && !r_v[NUM_STAGES-1]) |=> r_v[NUM_STAGES-1])
        else $error("item dropped before the output register");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.ready && !r_v[NUM_STAGES-2]) |=> !o_pix.valid)
        else $error("output shows an item that was never in the pipeline");

endmodule

`default_nettype wire

@@ hw/rtl/plb_lane.sv @@
// One color channel lane: mode result, divider, and the alpha-weighted difference.
`default_nettype none

module plb_lane import plb_pkg::*; (
    input  logic                  i_clk,
    input  logic [NUM_STAGES-1:0] i_en,
    input  t_cfg                  i_cfg,
    input  logic [7:0]            i_d,
    input  logic [7:0]            i_s,
    input  logic [7:0]            i_alpha,
    output logic [7:0]            o_d,
    output t_prod                 o_prod
);

    // stage 0
    logic [7:0]  r_s0_d, r_s0_s;
    // stage 1
    logic [7:0]  r_s1_d, r_s1_s;
    logic [8:0]  r_s1_div, r_s1_rem;
    logic [2:0]  r_s1_q;
    logic        r_s1_clamp;
    logic [15:0] r_s1_p_mul, r_s1_p_scr;
    logic [16:0] r_s1_p_ovl;
    // stage 2
    logic [7:0]  r_s2_d;
    logic [8:0]  r_s2_div, r_s2_rem;
    logic [5:0]  r_s2_q;
    logic        r_s2_clamp;
    logic [7:0]  r_s2_m_simple, r_s2_m_mul, r_s2_m_scr;
    logic [9:0]  r_s2_u;
    // stage 3
    logic [7:0]  r_s3_d, r_s3_m_pre;
    logic [17:0] r_s3_p_ovl2;
    // stage 4
    logic [7:0]         r_s4_d;
    logic signed [10:0] r_s4_diff;
    // stage 5
    logic [7:0]  r_s5_d;
    t_prod       r_s5_prod;

    logic [8:0]  n_s1_rem, n_s2_rem;
    logic [2:0]  n_s1_q;
    logic [5:0]  n_s2_q;
    logic [7:0]  n_s3_q;
    logic [9:0]  n_step1, n_step2, n_step3;
    logic [8:0]  n_s3_rem;
    logic [7:0]  n_s2_m_simple, n_s3_m_pre;
    logic [8:0]  n_sum;
    logic signed [MUL8_W-1:0] n_mul_full, n_scr_full, n_ovl_full, n_ovl2_full;
    logic [9:0]  n_m10;
    logic signed [10:0] n_s4_diff;
    t_prod       n_s5_prod;

    // divider, first three quotient bits
    always_comb begin
        n_s1_rem = {1'b0, r_s0_d};
        n_s1_q   = '0;
        for (int k = 0; k < 3; k++) begin
            n_step1  = div_step(n_s1_rem, 9'(r_s0_s) + 9'd1);
            n_s1_rem = n_step1[8:0];
            n_s1_q   = {n_s1_q[1:0], n_step1[9]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s0_d <= i_d;
            r_s0_s <= i_s;
        end
        if (i_en[1]) begin
            r_s1_d     <= r_s0_d;
            r_s1_s     <= r_s0_s;
            r_s1_div   <= 9'(r_s0_s) + 9'd1;
            r_s1_rem   <= n_s1_rem;
            r_s1_q     <= n_s1_q;
            r_s1_clamp <= r_s0_d > r_s0_s;
            r_s1_p_mul <= 16'(r_s0_s) * 16'(r_s0_d);
            r_s1_p_scr <= 16'(8'd255 - r_s0_s) * 16'(8'd255 - r_s0_d);
            r_s1_p_ovl <= 17'({r_s0_s, 1'b0}) * 17'(8'd255 - r_s0_d);
        end
    end

    // stage 2: simple modes, finish first products, three more divider bits
    always_comb begin
        n_sum = 9'(r_s1_d) + 9'(r_s1_s);
        unique case (i_cfg.mode)
            BLEND_NORMAL:     n_s2_m_simple = r_s1_s;
            BLEND_ADD:        n_s2_m_simple = n_sum[8] ? 8'd255 : n_sum[7:0];
            BLEND_SUBTRACT:   n_s2_m_simple = (r_s1_d > r_s1_s) ? r_s1_d - r_s1_s : 8'd0;
            BLEND_DIFFERENCE: n_s2_m_simple = (r_s1_d > r_s1_s) ? r_s1_d - r_s1_s
                                                                 : r_s1_s - r_s1_d;
            BLEND_LIGHTEN:    n_s2_m_simple = (r_s1_d > r_s1_s) ? r_s1_d : r_s1_s;
            BLEND_DARKEN:     n_s2_m_simple = (r_s1_d < r_s1_s) ? r_s1_d : r_s1_s;
            default:          n_s2_m_simple = 8'd0;
        endcase
        n_mul_full = mul8_round(signed'({8'd0, r_s1_p_mul}));
        n_scr_full = mul8_round(signed'({8'd0, r_s1_p_scr}));
        n_ovl_full = mul8_round(signed'({7'd0, r_s1_p_ovl}));

        n_s2_rem = r_s1_rem;
        n_s2_q   = {3'd0, r_s1_q};
        for (int k = 0; k < 3; k++) begin
            n_step2  = div_step(n_s2_rem, r_s1_div);
            n_s2_rem = n_step2[8:0];
            n_s2_q   = {n_s2_q[4:0], n_step2[9]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s2_d        <= r_s1_d;
            r_s2_div      <= r_s1_div;
            r_s2_rem      <= n_s2_rem;
            r_s2_q        <= n_s2_q;
            r_s2_clamp    <= r_s1_clamp;
            r_s2_m_simple <= n_s2_m_simple;
            r_s2_m_mul    <= n_mul_full[7:0];
            r_s2_m_scr    <= 8'd255 - n_scr_full[7:0];
            r_s2_u        <= 10'(r_s1_d) + n_ovl_full[9:0];
        end
    end

    // stage 3: last divider bits, pick the non-overlay mode result
    always_comb begin
        n_s3_rem = r_s2_rem;
        n_s3_q   = {2'd0, r_s2_q};
        for (int k = 0; k < 2; k++) begin
            n_step3  = div_step(n_s3_rem, r_s2_div);
            n_s3_rem = n_step3[8:0];
            n_s3_q   = {n_s3_q[6:0], n_step3[9]};
        end
        unique case (i_cfg.mode)
            BLEND_DIVIDE:   n_s3_m_pre = r_s2_clamp ? 8'd255 : n_s3_q;
            BLEND_MULTIPLY: n_s3_m_pre = r_s2_m_mul;
            BLEND_SCREEN:   n_s3_m_pre = r_s2_m_scr;
            default:        n_s3_m_pre = r_s2_m_simple;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s3_d      <= r_s2_d;
            r_s3_m_pre  <= n_s3_m_pre;
            r_s3_p_ovl2 <= 18'(r_s2_d) * 18'(r_s2_u);
        end
    end

    // stage 4: mode result minus destination
    always_comb begin
        n_ovl2_full = mul8_round(signed'({6'd0, r_s3_p_ovl2}));
        n_m10 = (i_cfg.mode == BLEND_OVERLAY) ? n_ovl2_full[9:0] : {2'd0, r_s3_m_pre};
        n_s4_diff = signed'({1'b0, n_m10}) - signed'({3'd0, r_s3_d});
    end

    assign n_s5_prod = PROD_W'(r_s4_diff) * PROD_W'(signed'({1'b0, i_alpha}));

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s4_d    <= r_s3_d;
            r_s4_diff <= n_s4_diff;
        end
        if (i_en[5]) begin
            r_s5_d    <= r_s4_d;
            r_s5_prod <= n_s5_prod;
        end
    end

    assign o_d    = r_s5_d;
    assign o_prod = r_s5_prod;

endmodule

`default_nettype wire

@@ hw/rtl/plb_alpha.sv @@
// Alpha unit: effective blend alpha for the color lanes and the updated pixel alpha.
`default_nettype none

module plb_alpha import plb_pkg::*; (
    input  logic                  i_clk,
    input  logic [NUM_STAGES-1:0] i_en,
    input  t_cfg                  i_cfg,
    input  logic [7:0]            i_da,
    input  logic [7:0]            i_sa,
    output logic [7:0]            o_alpha,
    output logic [7:0]            o_oa
);

    logic [7:0]  r_s0_da, r_s0_sa;
    logic [7:0]  r_s1_da, r_s1_sa;
    logic [15:0] r_s1_pa, r_s1_pb;
    logic [7:0]  r_s2_alpha, r_s2_oa;
    logic [7:0]  r_s3_alpha, r_s3_oa;
    logic [7:0]  r_s4_alpha, r_s4_oa;
    logic [7:0]  r_s5_oa;

    logic signed [MUL8_W-1:0] n_pa_full, n_pb_full;
    logic [8:0] n_sum;
    logic [7:0] n_s2_alpha, n_s2_oa;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s0_da <= i_da;
            r_s0_sa <= i_sa;
        end
        if (i_en[1]) begin
            r_s1_da <= r_s0_da;
            r_s1_sa <= r_s0_sa;
            r_s1_pa <= 16'(r_s0_sa) * 16'(i_cfg.opacity);
            r_s1_pb <= 16'(8'd255 - r_s0_sa) * 16'(r_s0_da);
        end
    end

    always_comb begin
        n_pa_full  = mul8_round(signed'({8'd0, r_s1_pa}));
        n_pb_full  = mul8_round(signed'({8'd0, r_s1_pb}));
        n_sum      = 9'(r_s1_sa) + n_pb_full[8:0];
        n_s2_alpha = i_cfg.src_has_alpha ? n_pa_full[7:0] : i_cfg.opacity;
        // keep destination alpha unless both pixels carry alpha and the mode is known
        priority if (i_cfg.mode > BLEND_OVERLAY || !i_cfg.src_has_alpha
                     || !i_cfg.dest_has_alpha) begin
            n_s2_oa = r_s1_da;
        end else if (i_cfg.mode == BLEND_NORMAL) begin
            n_s2_oa = n_sum[8] ? 8'd255 : n_sum[7:0];
        end else if (i_cfg.mode <= BLEND_DARKEN) begin
            n_s2_oa = 8'd255;
        end else begin
            n_s2_oa = (r_s1_da < r_s1_sa) ? r_s1_da : r_s1_sa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s2_alpha <= n_s2_alpha;
            r_s2_oa    <= n_s2_oa;
        end
        if (i_en[3]) begin
            r_s3_alpha <= r_s2_alpha;
            r_s3_oa    <= r_s2_oa;
        end
        if (i_en[4]) begin
            r_s4_alpha <= r_s3_alpha;
            r_s4_oa    <= r_s3_oa;
        end
        if (i_en[5]) begin
            r_s5_oa <= r_s4_oa;
        end
    end

    assign o_alpha = r_s4_alpha;
    assign o_oa    = r_s5_oa;

endmodule

`default_nettype wire

@@ hw/rtl/plb_merge.sv @@
// Output stage: rounds each lane's weighted difference, adds it back and packs the pixel.
`default_nettype none

module plb_merge import plb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_d [NUM_LANES],
    input  t_prod      i_prod [NUM_LANES],
    input  logic [7:0] i_oa,
    output t_pix_out   o_pix
);

    t_pix_out r_out;
    logic signed [MUL8_W-1:0] n_round [NUM_LANES];
    logic [7:0] n_col [NUM_LANES];

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            n_round[k] = mul8_round(MUL8_W'(i_prod[k]));
            // unknown mode codes pass the destination through
            n_col[k] = (i_cfg.mode > BLEND_OVERLAY) ? i_d[k] : n_round[k][7:0] + i_d[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.out_red   <= n_col[0];
            r_out.out_green <= n_col[1];
            r_out.out_blue  <= n_col[2];
            r_out.out_alpha <= i_oa;
        end
    end

    assign o_pix = r_out;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for pixel_layer_blend_core: random pixels and configs, blend predictor.
`default_nettype none

module testbench import plb_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 11;
    localparam int NUM_PHASES   = 24;
    localparam int PHASE_ITEMS  = 84;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_PRINTS   = 40;

    localparam logic [63:0] EDGE_PIXELS [7] = '{
        64'h00000000_00000000,
        64'hFFFFFFFF_FFFFFFFF,
        64'hFFFFFFFF_00000000,
        64'h00000000_FFFFFFFF,
        64'hAAAAAAAA_55555555,
        64'h55555555_AAAAAAAA,
        64'h1080FF90_C83C0060
    };
    // Distinct channels for overlay, full dest over a zero source for divide saturation.
    localparam logic [63:0] MIXED_PIXEL = 64'h1080FF90_C83C0060;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    plb_stream_if #(.t_payload(t_pix_in))  pix_in_if ();
    plb_stream_if #(.t_payload(t_pix_out)) pix_out_if ();

    pixel_layer_blend_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in_if.sink),
        .o_pix      (pix_out_if.source)
    );

    // Configuration as the block should hold it.
    logic [3:0] layer_mode    = BLEND_NORMAL;
    logic [7:0] layer_opacity = 8'd255;
    bit         src_alpha_on  = 1'b1;
    bit         dest_alpha_on = 1'b1;

    t_pix_in  pixels_to_send [$];
    t_pix_out blended_expected [$];
    int       n_errors = 0;
    int       cycle_count = 0;
    int       send_wait = 0;
    int       recv_wait = 0;
    bit       send_calm = 1'b0;
    bit       recv_calm = 1'b0;

    always #1 i_clk = ~i_clk;

    initial begin
        pix_in_if.valid = 1'b0;
        pix_in_if.data  = '0;
        pix_out_if.ready = 1'b0;
    end

    task automatic flag_error(string msg);
        if (n_errors < MAX_PRINTS) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        n_errors++;
    endtask

    // Rounded x*y/255 with floor shifts for negative products.
    function automatic int mul_div255(int x, int y);
        int t;
        t = x * y + 'h80;
        return ((t >>> 8) + t) >>> 8;
    endfunction

    function automatic int mode_result(logic [3:0] mode, int d, int s);
        int q;
        case (mode)
            BLEND_NORMAL:     return s;
            BLEND_ADD:        return (d + s > 255) ? 255 : d + s;
            BLEND_SUBTRACT:   return (d < s) ? 0 : d - s;
            BLEND_DIFFERENCE: return (d > s) ? d - s : s - d;
            BLEND_LIGHTEN:    return (d > s) ? d : s;
            BLEND_DARKEN:     return (d < s) ? d : s;
            BLEND_DIVIDE: begin
                q = (d * 256) / (s + 1);
                return (q > 255) ? 255 : q;
            end
            BLEND_MULTIPLY:   return mul_div255(s, d);
            BLEND_SCREEN:     return 255 - mul_div255(255 - s, 255 - d);
            default:          return mul_div255(d, d + mul_div255(2 * s, 255 - d));
        endcase
    endfunction

    function automatic t_pix_out blend_pixel(t_pix_in px);
        int d [3];
        int s [3];
        int da, sa, alpha, oa, m;
        t_pix_out res;
        d  = '{px.dest_red, px.dest_green, px.dest_blue};
        s  = '{px.src_red, px.src_green, px.src_blue};
        da = px.dest_alpha;
        sa = px.src_alpha;
        // Unused mode codes pass the destination through.
        if (layer_mode > BLEND_OVERLAY) begin
            return '{px.dest_red, px.dest_green, px.dest_blue, px.dest_alpha};
        end
        oa = da;
        if (src_alpha_on) begin
            alpha = mul_div255(sa, layer_opacity);
            if (dest_alpha_on) begin
                if (layer_mode == BLEND_NORMAL) begin
                    oa = sa + mul_div255(255 - sa, da);
                    if (oa > 255) oa = 255;
                end else if (layer_mode <= BLEND_DARKEN) begin
                    oa = 255;
                end else begin
                    oa = (da < sa) ? da : sa;
                end
            end
        end else begin
            alpha = layer_opacity;
        end
        for (int k = 0; k < 3; k++) begin
            m = mode_result(layer_mode, d[k], s[k]);
            d[k] = mul_div255(m - d[k], alpha) + d[k];
        end
        res.out_red   = 8'(d[0]);
        res.out_green = 8'(d[1]);
        res.out_blue  = 8'(d[2]);
        res.out_alpha = 8'(oa);
        return res;
    endfunction

    function automatic t_pix_in random_pixel();
        t_pix_in px;
        int i;
        for (i = 0; i < 8; i++) begin
            case ($urandom_range(0, 7))
                0:       px[8*i +: 8] = 8'h00;
                1:       px[8*i +: 8] = 8'hFF;
                default: px[8*i +: 8] = 8'($urandom);
            endcase
        end
        // Equal source and destination now and then.
        if ($urandom_range(0, 7) == 0) px[31:0] = px[63:32];
        return px;
    endfunction

    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // Driver: hold each item until accepted, then wait a drawn number of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_in_if.valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (pix_in_if.valid && pix_in_if.ready) begin
                blended_expected.push_back(blend_pixel(pix_in_if.data));
                if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
                send_wait = draw_wait(send_calm);
            end
            if (!pix_in_if.valid || pix_in_if.ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    pix_in_if.valid <= 1'b0;
                end else if (pixels_to_send.size() > 0) begin
                    pix_in_if.data  <= pixels_to_send.pop_front();
                    pix_in_if.valid <= 1'b1;
                end else begin
                    pix_in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest prediction, stall at random.
    always @(posedge i_clk) begin
        t_pix_out want;
        t_pix_out got;
        string    names [4];
        names = '{"red", "green", "blue", "alpha"};
        if (!i_rst_n) begin
            pix_out_if.ready <= 1'b0;
            recv_wait = 0;
        end else if (pix_out_if.valid && pix_out_if.ready) begin
            got = pix_out_if.data;
            if (blended_expected.size() == 0) begin
                flag_error($sformatf("unexpected result %h", got));
            end else begin
                want = blended_expected.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got[8*(3-i) +: 8] !== want[8*(3-i) +: 8]) begin
                        flag_error($sformatf("out_%s got %h want %h (mode %0d)", names[i],
                            got[8*(3-i) +: 8], want[8*(3-i) +: 8], layer_mode));
                    end
                end
            end
            if ($urandom_range(0, 39) == 0) recv_calm = ~recv_calm;
            recv_wait = draw_wait(recv_calm);
            pix_out_if.ready <= (recv_wait == 0);
        end else if (!pix_out_if.ready) begin
            if (recv_wait <= 1) pix_out_if.ready <= 1'b1;
            if (recv_wait > 0) recv_wait--;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        @(negedge i_clk);
        while (pixels_to_send.size() > 0 || pix_in_if.valid || blended_expected.size() > 0) begin
            @(negedge i_clk);
        end
    endtask

    // Write all four registers on back-to-back edges; spare data bits get noise.
    task automatic set_layer_config(logic [3:0] mode, logic [7:0] opac, bit sa, bit da);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_MODE;
        i_cfg_data <= {4'($urandom), mode};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IDX_OPACITY;
        i_cfg_data <= opac;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IDX_SRC_ALPHA;
        i_cfg_data <= {7'($urandom), sa};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IDX_DEST_ALPHA;
        i_cfg_data <= {7'($urandom), da};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        layer_mode    = mode;
        layer_opacity = opac;
        src_alpha_on  = sa;
        dest_alpha_on = da;
        @(negedge i_clk);
    endtask

    initial begin
        logic [3:0] mode;
        logic [7:0] opac;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset configuration: normal mode, fully opaque, both alphas.
        foreach (EDGE_PIXELS[i]) pixels_to_send.push_back(t_pix_in'(EDGE_PIXELS[i]));

        // One item per remaining mode code, unused codes included.
        for (int m = 1; m < 16; m++) begin
            set_layer_config(4'(m), 8'd255, 1'b1, 1'b1);
            pixels_to_send.push_back(t_pix_in'(MIXED_PIXEL));
        end
        set_layer_config(BLEND_NORMAL, 8'h80, 1'b0, 1'b1);
        pixels_to_send.push_back(t_pix_in'(MIXED_PIXEL));
        set_layer_config(BLEND_OVERLAY, 8'h80, 1'b1, 1'b0);
        pixels_to_send.push_back(t_pix_in'(MIXED_PIXEL));

        for (int p = 0; p < NUM_PHASES; p++) begin
            mode = (p < 16) ? 4'(p) : 4'($urandom_range(0, 9));
            case (p % 4)
                0:       opac = 8'd255;
                1:       opac = 8'd0;
                2:       opac = 8'($urandom);
                default: opac = 8'($urandom_range(1, 254));
            endcase
            set_layer_config(mode, opac, 1'($urandom), 1'($urandom));
            repeat (PHASE_ITEMS) pixels_to_send.push_back(random_pixel());
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ pixel_layer_blend_core.f @@
hw/rtl/plb_pkg.sv
hw/rtl/plb_stream_if.sv
hw/rtl/plb_lane.sv
hw/rtl/plb_alpha.sv
hw/rtl/plb_merge.sv
hw/rtl/pixel_layer_blend_core.sv
dv/testbench.sv
